// ===== rtl/dlrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrs_pkg: shared types and constants for the deck link receiver
// Event and input codes, command words, register indexes and reset values.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_SENT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STATUS  = 3'd1,
    EV_ACK     = 3'd2,
    EV_NACK    = 3'd3,
    EV_UNSUP   = 3'd4,
    EV_BADSUM  = 3'd5,
    EV_TIMEOUT = 3'd6
  } ev_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT    = 2'd1;

  localparam int PERIOD_W  = 15;
  localparam int TIMEOUT_W = 16;
  localparam int LEN_W     = 5;
  localparam int FLAGS_W   = 13;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 15'd100;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  localparam logic [15:0] CMD_STATUS = 16'h7920;
  localparam logic [15:0] CMD_ACK    = 16'h1001;
  localparam logic [15:0] CMD_NACK   = 16'h1112;

  localparam int STORE_DEPTH_DEF = 15;
  localparam int TIMER_BITS_DEF  = 16;

  function automatic logic [FLAGS_W-1:0] status_bits(
    input logic [7:0] b2,
    input logic [7:0] b3,
    input logic [7:0] b4,
    input logic [7:0] b10
  );
    status_bits = {b10[4], b10[5], b4[1], b4[2], b4[4], b3[7], b2[0], b2[5],
                   b3[5], b3[3], b3[2], b3[1], b3[0]};
  endfunction

endpackage

// ===== rtl/dlrs_ifs.sv =====
// ----------------------------------------------------------------------------
// dlrs_ifs: channel interfaces for the deck link receiver
// Input request, result and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface dlrs_in_if;
  logic          valid;
  logic          ready;
  dlrs_pkg::kind_t kind;
  logic [7:0]    rx_byte;
  modport source(output valid, kind, rx_byte, input ready);
  modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface dlrs_out_if;
  logic                          valid;
  logic                          ready;
  dlrs_pkg::ev_t                 packet_event;
  logic [7:0]                    nack_code;
  logic [dlrs_pkg::FLAGS_W-1:0]  status_flags;
  logic                          online;
  logic                          send_status_request;
  logic                          reply_pending;
  modport source(output valid, packet_event, nack_code, status_flags, online,
                 send_status_request, reply_pending, input ready);
  modport sink(input valid, packet_event, nack_code, status_flags, online,
               send_status_request, reply_pending, output ready);
endinterface

interface dlrs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dlrs_pkg::CFG_IDX_W-1:0]  index;
  logic [dlrs_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/deck_link_receiver_status.sv =====
// ----------------------------------------------------------------------------
// deck_link_receiver_status: deck reply receiver and status keeper
// Assembles reply packets, checks the sum, decodes status/ACK/NACK and runs
// the millisecond timers for reply timeout, status polling and online state.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled (received byte,
// millisecond tick or command sent) and gives exactly one result per request:
// the request lands in an input register and one pass of packet
// and timer logic loads the result register. Input and output stall
// independently; a full result register holds while the next request waits
// in the input register. The user writes registers through the cfg channel
// only while no request is in flight; the block itself does not enforce it.
module deck_link_receiver_status #(
  parameter int STORE_DEPTH = dlrs_pkg::STORE_DEPTH_DEF,
  parameter int TIMER_BITS  = dlrs_pkg::TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dlrs_in_if.sink     in_if,
  dlrs_out_if.source  out_if,
  dlrs_cfg_if.sink    cfg_if
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int CMP_W  = (IDX_W > dlrs_pkg::LEN_W) ? IDX_W : dlrs_pkg::LEN_W;
  localparam int P3_W   = dlrs_pkg::PERIOD_W + 2;
  localparam int TCMP_W = (TIMER_BITS > P3_W) ? TIMER_BITS : P3_W;

  // config
  logic [dlrs_pkg::PERIOD_W-1:0]  period_r;
  logic [P3_W-1:0]                period3_r;
  logic [dlrs_pkg::TIMEOUT_W-1:0] timeout_r;

  // input stage
  logic             in_v_r;
  dlrs_pkg::kind_t  kind_r;
  logic [7:0]       byte_r;
  logic             adv;

  // state
  logic [7:0]                   store_r [STORE_DEPTH];
  logic [IDX_W-1:0]             wi_r, wi_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic [dlrs_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                         drop_r, drop_nxt;
  logic [7:0]                   prior_r, prior_nxt;
  logic [dlrs_pkg::FLAGS_W-1:0] flags_r, flags_nxt;
  logic                         online_r, online_nxt;
  logic                         await_r, await_nxt;
  logic [TIMER_BITS-1:0]        t_byte_r, t_byte_nxt;
  logic [TIMER_BITS-1:0]        t_req_r, t_req_nxt;
  logic [TIMER_BITS-1:0]        t_stat_r, t_stat_nxt;

  // output stage
  logic                         out_v_r;
  dlrs_pkg::ev_t                ev_r, ev_nxt;
  logic [7:0]                   code_r, code_nxt;
  logic                         send_r, send_nxt;

  // packet decode
  logic [7:0]             b0, b1, b2, b3, b4, b10;
  logic [7:0]             sum_eff;
  logic [dlrs_pkg::LEN_W-1:0] len_eff;
  logic [IDX_W:0]         wi_inc;
  logic [TIMER_BITS-1:0]  tb_inc, tr_inc, ts_inc;

  assign adv         = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || adv;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= dlrs_pkg::PERIOD_RST;
      period3_r <= P3_W'(dlrs_pkg::PERIOD_RST) * P3_W'(3);
      timeout_r <= dlrs_pkg::TIMEOUT_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == dlrs_pkg::CFG_STATUS_PERIOD) begin
        period_r  <= cfg_if.data[dlrs_pkg::PERIOD_W-1:0];
        period3_r <= P3_W'(cfg_if.data[dlrs_pkg::PERIOD_W-1:0])
                   + P3_W'({cfg_if.data[dlrs_pkg::PERIOD_W-1:0], 1'b0});
      end else if (cfg_if.index == dlrs_pkg::CFG_RX_TIMEOUT) begin
        timeout_r <= cfg_if.data[dlrs_pkg::TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      kind_r <= in_if.kind;
      byte_r <= in_if.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && kind_r == dlrs_pkg::KIND_BYTE && !drop_r) begin
      store_r[wi_r] <= byte_r;
    end
  end

  // current byte forwarded over the store entry it is written to
  assign b0  = (wi_r == IDX_W'(0))  ? byte_r : store_r[0];
  assign b1  = (wi_r == IDX_W'(1))  ? byte_r : store_r[1];
  assign b2  = (wi_r == IDX_W'(2))  ? byte_r : store_r[2];
  assign b3  = (wi_r == IDX_W'(3))  ? byte_r : store_r[3];
  assign b4  = (wi_r == IDX_W'(4))  ? byte_r : store_r[4];
  assign b10 = (wi_r == IDX_W'(10)) ? byte_r : store_r[10];

  assign sum_eff = (wi_r == '0) ? 8'd0 : sum_r;
  assign len_eff = (wi_r == '0) ? (dlrs_pkg::LEN_W'(byte_r[3:0]) + dlrs_pkg::LEN_W'(2))
                                : len_r;
  assign wi_inc  = {1'b0, wi_r} + (IDX_W+1)'(1);

  assign tb_inc = (&t_byte_r) ? t_byte_r : t_byte_r + TIMER_BITS'(1);
  assign tr_inc = (&t_req_r)  ? t_req_r  : t_req_r  + TIMER_BITS'(1);
  assign ts_inc = (&t_stat_r) ? t_stat_r : t_stat_r + TIMER_BITS'(1);

  always_comb begin
    wi_nxt     = wi_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    drop_nxt   = drop_r;
    prior_nxt  = prior_r;
    flags_nxt  = flags_r;
    online_nxt = online_r;
    await_nxt  = await_r;
    t_byte_nxt = t_byte_r;
    t_req_nxt  = t_req_r;
    t_stat_nxt = t_stat_r;
    ev_nxt     = dlrs_pkg::EV_NONE;
    code_nxt   = 8'd0;
    send_nxt   = 1'b0;
    unique case (kind_r)
      dlrs_pkg::KIND_BYTE: begin
        t_byte_nxt = '0;
        if (drop_r) begin
          drop_nxt = 1'b0;
        end else begin
          await_nxt = 1'b0;
          len_nxt   = len_eff;
          sum_nxt   = sum_eff;
          if (CMP_W'(wi_r) == CMP_W'(len_eff)) begin
            wi_nxt = '0;
            if (sum_eff == byte_r) begin
              priority if ({b0, b1} == dlrs_pkg::CMD_STATUS) begin
                ev_nxt     = dlrs_pkg::EV_STATUS;
                online_nxt = 1'b1;
                t_stat_nxt = '0;
                if (sum_eff != prior_r) begin
                  prior_nxt = sum_eff;
                  flags_nxt = dlrs_pkg::status_bits(b2, b3, b4, b10);
                end
              end else if ({b0, b1} == dlrs_pkg::CMD_ACK) begin
                ev_nxt = dlrs_pkg::EV_ACK;
              end else if ({b0, b1} == dlrs_pkg::CMD_NACK) begin
                ev_nxt   = dlrs_pkg::EV_NACK;
                code_nxt = b2;
              end else begin
                ev_nxt = dlrs_pkg::EV_UNSUP;
              end
            end else begin
              ev_nxt   = dlrs_pkg::EV_BADSUM;
              drop_nxt = 1'b1;
            end
          end else begin
            sum_nxt = sum_eff + byte_r;
            wi_nxt  = (wi_inc >= (IDX_W+1)'(STORE_DEPTH)) ? '0 : wi_inc[IDX_W-1:0];
          end
        end
      end
      dlrs_pkg::KIND_TICK: begin
        t_byte_nxt = tb_inc;
        t_req_nxt  = tr_inc;
        t_stat_nxt = ts_inc;
        if ((wi_r != '0 || await_r) && TCMP_W'(tb_inc) > TCMP_W'(timeout_r)) begin
          wi_nxt    = '0;
          await_nxt = 1'b0;
          drop_nxt  = 1'b0;
          ev_nxt    = dlrs_pkg::EV_TIMEOUT;
        end
        if (TCMP_W'(tr_inc) > TCMP_W'(period_r)) begin
          send_nxt   = 1'b1;
          t_req_nxt  = '0;
          t_byte_nxt = '0;
          await_nxt  = 1'b1;
        end
        if (TCMP_W'(ts_inc) > TCMP_W'(period3_r)) begin
          online_nxt = 1'b0;
        end
      end
      dlrs_pkg::KIND_SENT: begin
        await_nxt  = 1'b1;
        t_byte_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r     <= '0;
      sum_r    <= '0;
      len_r    <= '0;
      drop_r   <= 1'b0;
      prior_r  <= '0;
      flags_r  <= '0;
      online_r <= 1'b0;
      await_r  <= 1'b0;
      t_byte_r <= '0;
      t_req_r  <= '0;
      t_stat_r <= '0;
    end else if (adv) begin
      wi_r     <= wi_nxt;
      sum_r    <= sum_nxt;
      len_r    <= len_nxt;
      drop_r   <= drop_nxt;
      prior_r  <= prior_nxt;
      flags_r  <= flags_nxt;
      online_r <= online_nxt;
      await_r  <= await_nxt;
      t_byte_r <= t_byte_nxt;
      t_req_r  <= t_req_nxt;
      t_stat_r <= t_stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r   <= ev_nxt;
      code_r <= code_nxt;
      send_r <= send_nxt;
    end
  end

  assign out_if.valid               = out_v_r;
  assign out_if.packet_event        = ev_r;
  assign out_if.nack_code           = code_r;
  assign out_if.status_flags        = flags_r;
  assign out_if.online              = online_r;
  assign out_if.send_status_request = send_r;
  assign out_if.reply_pending       = await_r;

  a_send_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && send_r |-> await_r)
    else $error("status request without reply pending");

  a_code_only_nack: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && code_r != 8'd0 |-> ev_r == dlrs_pkg::EV_NACK)
    else $error("nack code on non-nack result");

  a_badsum_drops: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ev_nxt == dlrs_pkg::EV_BADSUM |=> drop_r && wi_r == '0)
    else $error("bad checksum did not arm byte drop");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ev_nxt == dlrs_pkg::EV_TIMEOUT |=> wi_r == '0 && !drop_r)
    else $error("receive timeout left packet state");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (IDX_W+1)'(wi_r) < (IDX_W+1)'(STORE_DEPTH))
    else $error("write index out of store range");

endmodule

// ===== verif/tb_deck_link_receiver_status.sv =====
// ----------------------------------------------------------------------------
// tb_deck_link_receiver_status: self-checking bench for the deck link receiver
// Feeds received bytes, millisecond ticks and command-sent requests through
// the input channel, keeps a cycle-free model of packet assembly, checksum,
// status decode and the poll/timeout/online timers, and checks every result
// in order. Runs a short directed sequence, then random traffic over several
// register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_deck_link_receiver_status;

  localparam int   DEPTH         = dlrs_pkg::STORE_DEPTH_DEF;
  localparam int   TIMER_MAX     = (1 << dlrs_pkg::TIMER_BITS_DEF) - 1;
  localparam int   SETTLE_CYCLES = 4;
  localparam int   NUM_PHASES    = 9;
  localparam int   PHASE_ITEMS   = 205;
  localparam dlrs_pkg::kind_t KIND_NOP = dlrs_pkg::kind_t'(2'd3);

  typedef struct packed {
    dlrs_pkg::kind_t kind;
    logic [7:0]      rx_byte;
  } link_request_t;

  typedef struct packed {
    dlrs_pkg::ev_t                ev;
    logic [7:0]                   code;
    logic [dlrs_pkg::FLAGS_W-1:0] flags;
    logic                         online;
    logic                         poll;
    logic                         pending;
  } link_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  dlrs_in_if  in_ch();
  dlrs_out_if out_ch();
  dlrs_cfg_if cfg_ch();

  deck_link_receiver_status i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // link state as the block should hold it
  logic [7:0]                   pkt_bytes [DEPTH];
  int                           wr_pos          = 0;
  int                           pkt_len         = 0;
  logic [7:0]                   sum_acc         = 8'h00;
  logic [7:0]                   last_status_sum = 8'h00;
  bit                           skip_byte       = 1'b0;
  bit                           link_online     = 1'b0;
  bit                           reply_wait      = 1'b0;
  logic [dlrs_pkg::FLAGS_W-1:0] transport       = '0;
  int                           ms_byte         = 0;
  int                           ms_poll         = 0;
  int                           ms_status       = 0;
  int                           period_ms       = int'(dlrs_pkg::PERIOD_RST);
  int                           timeout_ms      = int'(dlrs_pkg::TIMEOUT_RST);

  link_request_t link_requests_pending[$];
  link_result_t  link_results_due[$];
  byte_q_t       last_status_body;
  int            requests_queued = 0;
  int            failures        = 0;

  bit in_taken  = 1'b0;
  bit in_calm   = 1'b0;
  int in_gap    = 0;
  bit out_taken = 1'b0;
  bit out_calm  = 1'b0;
  int out_stall = 0;

  int poll_periods [NUM_PHASES] = '{1, 20000, 0, 4, 12, 7, 20000, 3, 25};
  int rx_timeouts  [NUM_PHASES] = '{1, 60000, 2, 9, 5, 60000, 1, 30, 14};

  function automatic int idle_span();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic predict_link_result(input dlrs_pkg::kind_t kind, input logic [7:0] b);
    link_result_t r;
    logic [15:0]  cmd;
    r = '0;
    r.ev = dlrs_pkg::EV_NONE;
    if (kind == dlrs_pkg::KIND_BYTE) begin
      ms_byte = 0;
      if (skip_byte) begin
        skip_byte = 1'b0;
      end else begin
        reply_wait = 1'b0;
        if (wr_pos < DEPTH) pkt_bytes[wr_pos] = b;
        if (wr_pos == 0) begin
          sum_acc = 8'h00;
          pkt_len = int'(b[3:0]) + 2;
        end
        if (wr_pos == pkt_len) begin
          wr_pos = 0;
          if (sum_acc != b) begin
            r.ev = dlrs_pkg::EV_BADSUM;
            skip_byte = 1'b1;
          end else begin
            cmd = {pkt_bytes[0], pkt_bytes[1]};
            if (cmd == dlrs_pkg::CMD_STATUS) begin
              r.ev = dlrs_pkg::EV_STATUS;
              link_online = 1'b1;
              ms_status = 0;
              if (sum_acc != last_status_sum) begin
                last_status_sum = sum_acc;
                transport[0]  = pkt_bytes[3][0];
                transport[1]  = pkt_bytes[3][1];
                transport[2]  = pkt_bytes[3][2];
                transport[3]  = pkt_bytes[3][3];
                transport[4]  = pkt_bytes[3][5];
                transport[5]  = pkt_bytes[2][5];
                transport[6]  = pkt_bytes[2][0];
                transport[7]  = pkt_bytes[3][7];
                transport[8]  = pkt_bytes[4][4];
                transport[9]  = pkt_bytes[4][2];
                transport[10] = pkt_bytes[4][1];
                transport[11] = pkt_bytes[10][5];
                transport[12] = pkt_bytes[10][4];
              end
            end else if (cmd == dlrs_pkg::CMD_ACK) begin
              r.ev = dlrs_pkg::EV_ACK;
            end else if (cmd == dlrs_pkg::CMD_NACK) begin
              r.ev = dlrs_pkg::EV_NACK;
              r.code = pkt_bytes[2];
            end else begin
              r.ev = dlrs_pkg::EV_UNSUP;
            end
          end
        end else begin
          sum_acc = sum_acc + b;
          wr_pos++;
          if (wr_pos >= DEPTH) wr_pos = 0;
        end
      end
    end else if (kind == dlrs_pkg::KIND_TICK) begin
      if (ms_byte < TIMER_MAX) ms_byte++;
      if (ms_poll < TIMER_MAX) ms_poll++;
      if (ms_status < TIMER_MAX) ms_status++;
      if ((wr_pos > 0 || reply_wait) && ms_byte > timeout_ms) begin
        wr_pos = 0;
        reply_wait = 1'b0;
        skip_byte = 1'b0;
        r.ev = dlrs_pkg::EV_TIMEOUT;
      end
      if (ms_poll > period_ms) begin
        r.poll = 1'b1;
        ms_poll = 0;
        ms_byte = 0;
        reply_wait = 1'b1;
      end
      if (ms_status > 3 * period_ms) link_online = 1'b0;
    end else if (kind == dlrs_pkg::KIND_SENT) begin
      reply_wait = 1'b1;
      ms_byte = 0;
    end
    r.flags   = transport;
    r.online  = link_online;
    r.pending = reply_wait;
    link_results_due.push_back(r);
  endtask

  task automatic add_request(input dlrs_pkg::kind_t kind, input logic [7:0] b);
    link_request_t q;
    q.kind = kind;
    q.rx_byte = b;
    link_requests_pending.push_back(q);
    if (kind != KIND_NOP) requests_queued++;
  endtask

  // appends the checksum (broken if spoil, then followed by a byte to be dropped), optionally sprinkles ticks
  task automatic queue_packet(input byte_q_t body, input bit spoil, input bit sprinkle);
    logic [7:0] chk;
    chk = 8'h00;
    foreach (body[i]) chk = chk + body[i];
    if (spoil) chk = chk ^ 8'($urandom_range(1, 255));
    body.push_back(chk);
    foreach (body[i]) begin
      if (sprinkle && $urandom_range(0, 11) == 0)
        add_request(dlrs_pkg::KIND_TICK, 8'($urandom));
      add_request(dlrs_pkg::KIND_BYTE, body[i]);
    end
    if (spoil) add_request(dlrs_pkg::KIND_BYTE, 8'($urandom));
  endtask

  task automatic queue_random_traffic(input int count);
    byte_q_t    body;
    int         stop_at;
    int         pick;
    logic [7:0] head;
    stop_at = requests_queued + count;
    while (requests_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      body = {};
      if (pick < 20) begin
        if (last_status_body.size() != 0 && $urandom_range(0, 3) == 0) begin
          body = last_status_body;
        end else begin
          body.push_back(dlrs_pkg::CMD_STATUS[15:8]);
          body.push_back(dlrs_pkg::CMD_STATUS[7:0]);
          repeat (9) body.push_back(8'($urandom));
          last_status_body = body;
        end
        queue_packet(body, $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 30) begin
        body.push_back(dlrs_pkg::CMD_ACK[15:8]);
        body.push_back(dlrs_pkg::CMD_ACK[7:0]);
        queue_packet(body, $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 40) begin
        body.push_back(dlrs_pkg::CMD_NACK[15:8]);
        body.push_back(dlrs_pkg::CMD_NACK[7:0]);
        body.push_back(8'($urandom));
        queue_packet(body, $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 50) begin
        head = {4'($urandom), 4'($urandom_range(0, 12))};
        body.push_back(head);
        body.push_back(8'($urandom));
        repeat (int'(head[3:0])) body.push_back(8'($urandom));
        queue_packet(body, $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 53) begin
        // header length beyond the store: packet restarts on wrap
        add_request(dlrs_pkg::KIND_BYTE, {4'($urandom), 4'($urandom_range(13, 15))});
        repeat ($urandom_range(14, 18)) add_request(dlrs_pkg::KIND_BYTE, 8'($urandom));
      end else if (pick < 83) begin
        repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6))
          add_request(dlrs_pkg::KIND_TICK, 8'($urandom));
      end else if (pick < 91) begin
        add_request(dlrs_pkg::KIND_SENT, 8'($urandom));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 3)) add_request(dlrs_pkg::KIND_BYTE, 8'($urandom));
      end else begin
        add_request(KIND_NOP, 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [dlrs_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = dlrs_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == dlrs_pkg::CFG_STATUS_PERIOD)
      period_ms = value % (1 << dlrs_pkg::PERIOD_W);
    else if (idx == dlrs_pkg::CFG_RX_TIMEOUT)
      timeout_ms = value % (1 << dlrs_pkg::TIMEOUT_W);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    while (link_requests_pending.size() != 0 || in_ch.valid || link_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_link_result(in_ch.kind, in_ch.rx_byte);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    link_request_t q;
    if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid = 1'b0;
      end else if (link_requests_pending.size() != 0) begin
        q = link_requests_pending.pop_front();
        in_ch.valid   = 1'b1;
        in_ch.kind    = q.kind;
        in_ch.rx_byte = q.rx_byte;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : idle_span();
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    link_result_t seen;
    link_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_taken    = 1'b1;
      seen.ev      = out_ch.packet_event;
      seen.code    = out_ch.nack_code;
      seen.flags   = out_ch.status_flags;
      seen.online  = out_ch.online;
      seen.poll    = out_ch.send_status_request;
      seen.pending = out_ch.reply_pending;
      if (link_results_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: ev=%0d code=%02h flags=%04h online=%0b poll=%0b pend=%0b",
                   seen.ev, seen.code, seen.flags, seen.online, seen.poll, seen.pending);
      end else begin
        want = link_results_due.pop_front();
        if (seen !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch: ev %0d/%0d code %02h/%02h flags %04h/%04h (expected/actual)",
                     want.ev, seen.ev, want.code, seen.code, want.flags, seen.flags);
            $display("          online %0b/%0b poll %0b/%0b pend %0b/%0b",
                     want.online, seen.online, want.poll, seen.poll,
                     want.pending, seen.pending);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_stall = out_calm ? 0 : idle_span();
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  initial begin
    byte_q_t body;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = dlrs_pkg::KIND_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = dlrs_pkg::CFG_STATUS_PERIOD;
    cfg_ch.data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: full status, NACK, bad sum with dropped byte, unknown command
    body = {};
    body.push_back(dlrs_pkg::CMD_STATUS[15:8]);
    body.push_back(dlrs_pkg::CMD_STATUS[7:0]);
    repeat (9) body.push_back(8'hFF);
    queue_packet(body, 1'b0, 1'b0);
    body = {};
    body.push_back(dlrs_pkg::CMD_NACK[15:8]);
    body.push_back(dlrs_pkg::CMD_NACK[7:0]);
    body.push_back(8'hFF);
    queue_packet(body, 1'b0, 1'b0);
    body = {};
    body.push_back(dlrs_pkg::CMD_ACK[15:8]);
    body.push_back(dlrs_pkg::CMD_ACK[7:0]);
    queue_packet(body, 1'b1, 1'b0);
    body = {};
    body.push_back(8'h00);
    body.push_back(8'h00);
    queue_packet(body, 1'b0, 1'b0);
    add_request(dlrs_pkg::KIND_SENT, 8'h00);
    add_request(KIND_NOP, 8'hFF);
    add_request(dlrs_pkg::KIND_TICK, 8'h00);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(dlrs_pkg::CFG_STATUS_PERIOD, poll_periods[p]);
      write_reg(dlrs_pkg::CFG_RX_TIMEOUT, rx_timeouts[p]);
      queue_random_traffic(PHASE_ITEMS);
      settle();
    end

    if (failures == 0 && link_results_due.size() == 0)
      $display("[deck_link_receiver_status] OK");
    else
      $display("[deck_link_receiver_status] ERROR");
    $finish;
  end

  initial begin
    #8000000;
    $display("[deck_link_receiver_status] ERROR");
    $finish;
  end

endmodule
